/* hdl/sssl_pkg.sv */
// ----------------------------------------------------------------------------
// sssl_pkg
// Shared widths, constants, register codes and divider handshake types for the
// speed scheduled slew limiter.
// ----------------------------------------------------------------------------
package sssl_pkg;

  // Field and table geometry
  localparam int VAL_W        = 16;
  localparam int TABLE_POINTS = 4;
  localparam int POINTS_W     = 64;
  localparam int PT_IDX_W     = $clog2(TABLE_POINTS);
  localparam int NUM_LIMITED  = 6;
  localparam int CH_W         = $clog2(NUM_LIMITED);

  // Per-tick rise step: (rate * mul) >> shift
  localparam logic [VAL_W-1:0] GAIN_STEP_MUL   = 16'd262;
  localparam logic [VAL_W-1:0] TORQUE_STEP_MUL = 16'd1049;
  localparam int STEP_SHIFT = 10;
  localparam int RISE_W     = 17;

  // Divider: quotient is known to fit VAL_W bits
  localparam int NUM_W           = 2 * VAL_W;
  localparam int DIV_BITS_PER_CY = 2;
  localparam int DIV_CYCLES      = VAL_W / DIV_BITS_PER_CY;
  localparam int DIV_CNT_W       = $clog2(DIV_CYCLES);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_SPEED    = 3'd0,
    REG_GAIN_RATE     = 3'd1,
    REG_TORQUE_SPEED  = 3'd2,
    REG_TORQUE_RATE   = 3'd3,
    REG_GAIN_FALL     = 3'd4,
    REG_TORQUE_FALL   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [VAL_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quot;
  } div_rsp_t;

endpackage

/* hdl/sssl_if.sv */
// ----------------------------------------------------------------------------
// sssl_sample_if / sssl_result_if
// Valid/ready channels carrying one tick's sample and one tick's result.
// ----------------------------------------------------------------------------
interface sssl_sample_if;
  logic                        valid;
  logic                        ready;
  logic [sssl_pkg::VAL_W-1:0]  vehicle_speed;
  logic [sssl_pkg::VAL_W-1:0]  eot_gain_target;
  logic [sssl_pkg::VAL_W-1:0]  ramp_mult_target;
  logic [sssl_pkg::VAL_W-1:0]  eot_limit_target;
  logic [sssl_pkg::VAL_W-1:0]  stall_limit_target;
  logic [sssl_pkg::VAL_W-1:0]  speed_limit_target;
  logic [sssl_pkg::VAL_W-1:0]  thermal_limit_target;

  modport source (
    output valid, vehicle_speed, eot_gain_target, ramp_mult_target,
           eot_limit_target, stall_limit_target, speed_limit_target,
           thermal_limit_target,
    input  ready
  );
  modport sink (
    input  valid, vehicle_speed, eot_gain_target, ramp_mult_target,
           eot_limit_target, stall_limit_target, speed_limit_target,
           thermal_limit_target,
    output ready
  );
endinterface

interface sssl_result_if;
  logic                        valid;
  logic                        ready;
  logic [sssl_pkg::VAL_W-1:0]  eot_gain_out;
  logic [sssl_pkg::VAL_W-1:0]  ramp_mult_out;
  logic [sssl_pkg::VAL_W-1:0]  eot_limit_out;
  logic [sssl_pkg::VAL_W-1:0]  stall_limit_out;
  logic [sssl_pkg::VAL_W-1:0]  speed_limit_out;
  logic [sssl_pkg::VAL_W-1:0]  thermal_limit_out;

  modport source (
    output valid, eot_gain_out, ramp_mult_out, eot_limit_out,
           stall_limit_out, speed_limit_out, thermal_limit_out,
    input  ready
  );
  modport sink (
    input  valid, eot_gain_out, ramp_mult_out, eot_limit_out,
           stall_limit_out, speed_limit_out, thermal_limit_out,
    output ready
  );
endinterface

/* hdl/sssl_divider.sv */
// ----------------------------------------------------------------------------
// sssl_divider
// Iterative restoring divider, two quotient bits per cycle. The caller
// guarantees num < den * 2^VAL_W, so the quotient fits VAL_W bits.
// ----------------------------------------------------------------------------
module sssl_divider (
  input  logic                clk,
  input  logic                rst,
  input  sssl_pkg::div_req_t  req,
  output sssl_pkg::div_rsp_t  rsp
);

  logic [sssl_pkg::VAL_W-1:0]     rem;
  logic [sssl_pkg::VAL_W-1:0]     low;
  logic [sssl_pkg::VAL_W-1:0]     den;
  logic [sssl_pkg::VAL_W-1:0]     quot;
  logic [sssl_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;

  logic [sssl_pkg::VAL_W-1:0] rem_next;
  logic [sssl_pkg::VAL_W-1:0] low_next;
  logic [sssl_pkg::VAL_W-1:0] quot_next;

  // Shift in one numerator bit per step, subtract when it fits
  always_comb begin
    logic [sssl_pkg::VAL_W:0] trial;
    rem_next  = rem;
    low_next  = low;
    quot_next = quot;
    for (int k = 0; k < sssl_pkg::DIV_BITS_PER_CY; k++) begin
      trial    = {rem_next, low_next[sssl_pkg::VAL_W-1]};
      low_next = {low_next[sssl_pkg::VAL_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_next  = sssl_pkg::VAL_W'(trial - {1'b0, den});
        quot_next = {quot_next[sssl_pkg::VAL_W-2:0], 1'b1};
      end else begin
        rem_next  = trial[sssl_pkg::VAL_W-1:0];
        quot_next = {quot_next[sssl_pkg::VAL_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == sssl_pkg::DIV_CNT_W'(sssl_pkg::DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.num[sssl_pkg::NUM_W-1:sssl_pkg::VAL_W];
      low  <= req.num[sssl_pkg::VAL_W-1:0];
      den  <= req.den;
      quot <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      low  <= low_next;
      quot <= quot_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

/* hdl/speed_scheduled_slew_limiter.sv */
// ----------------------------------------------------------------------------
// speed_scheduled_slew_limiter
// One transfer per 2 ms tick: vehicle speed and six targets in, six slew
// limited values out. A gain rise rate and a torque rise rate are interpolated
// from four-point speed tables (clamped to the end rates outside the table),
// scaled to per-tick rise steps, and each held value moves toward its target
// by at most that rise step up or the configured fall step down, saturating
// at 0 and 65535. Each table passes through a seek state and a step state in
// which the shared multiplier scales its rate to a per-tick rise step; a table
// whose speed falls inside a segment also passes through a multiply state and
// a wait on the shared two-bit-per-cycle divider. The six held values then go
// one at a time through a single slew unit, and the result register is loaded
// once the last of them is done. The sample channel is ready only while the
// sequencer is idle; the result register lets the next sample be taken while
// a result still waits, and a finished tick holds until that register is
// free. Write configuration only while idle.
// ----------------------------------------------------------------------------
module speed_scheduled_slew_limiter (
  input  logic                             clk,
  input  logic                             rst,
  sssl_sample_if.sink                      sample,
  sssl_result_if.source                    result,
  input  logic                             cfg_we,
  input  logic [sssl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sssl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SEEK = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_STEP = 7'b0010000,
    ST_SLEW = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  typedef logic [sssl_pkg::VAL_W-1:0] val_t;

  function automatic val_t pt(input logic [sssl_pkg::POINTS_W-1:0] p, input int i);
    pt = p[sssl_pkg::VAL_W*i +: sssl_pkg::VAL_W];
  endfunction

  // Configuration registers
  logic [sssl_pkg::POINTS_W-1:0] gain_speed_points;
  logic [sssl_pkg::POINTS_W-1:0] gain_rate_points;
  logic [sssl_pkg::POINTS_W-1:0] torque_speed_points;
  logic [sssl_pkg::POINTS_W-1:0] torque_rate_points;
  val_t                          gain_fall_step;
  val_t                          torque_fall_step;

  // Sequencer and working registers
  state_t                       state;
  logic                         tbl;     // 0: gain table, 1: torque table
  logic [sssl_pkg::CH_W-1:0]    ch;
  val_t                         speed;
  val_t                         tgt  [sssl_pkg::NUM_LIMITED];
  val_t                         held [sssl_pkg::NUM_LIMITED];
  val_t                         res  [sssl_pkg::NUM_LIMITED];
  logic                         res_valid;
  val_t                         y0_r;
  val_t                         dy_r;
  val_t                         off_r;
  val_t                         dx_r;
  logic                         neg_r;
  val_t                         rate_r;
  logic [sssl_pkg::RISE_W-1:0]  rise_g;
  logic [sssl_pkg::RISE_W-1:0]  rise_t;

  sssl_pkg::div_req_t div_req;
  sssl_pkg::div_rsp_t div_rsp;

  // ---- configuration writes; writes beyond the list are dropped ----
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_speed_points   <= '0;
      gain_rate_points    <= '0;
      torque_speed_points <= '0;
      torque_rate_points  <= '0;
      gain_fall_step      <= '0;
      torque_fall_step    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sssl_pkg::REG_GAIN_SPEED:   gain_speed_points   <= cfg_data;
        sssl_pkg::REG_GAIN_RATE:    gain_rate_points    <= cfg_data;
        sssl_pkg::REG_TORQUE_SPEED: torque_speed_points <= cfg_data;
        sssl_pkg::REG_TORQUE_RATE:  torque_rate_points  <= cfg_data;
        sssl_pkg::REG_GAIN_FALL:    gain_fall_step      <= cfg_data[sssl_pkg::VAL_W-1:0];
        sssl_pkg::REG_TORQUE_FALL:  torque_fall_step    <= cfg_data[sssl_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- segment seek over the selected table ----
  // Scan segments in order; take the first whose upper breakpoint lies above
  // the speed. Speed at or below the first point, or past every segment,
  // takes an end rate with no division.
  logic [sssl_pkg::POINTS_W-1:0] xs;
  logic [sssl_pkg::POINTS_W-1:0] ys;
  logic                          below_first;
  logic                          found;
  logic [sssl_pkg::PT_IDX_W-1:0] seg;
  val_t                          x0;
  val_t                          x1;
  val_t                          y0;
  val_t                          y1;

  assign xs = tbl ? torque_speed_points : gain_speed_points;
  assign ys = tbl ? torque_rate_points  : gain_rate_points;
  assign below_first = (speed <= pt(xs, 0));

  always_comb begin
    found = 1'b0;
    seg   = '0;
    for (int i = 0; i < sssl_pkg::TABLE_POINTS - 1; i++) begin
      if (!found && (speed < pt(xs, i + 1))) begin
        found = 1'b1;
        seg   = sssl_pkg::PT_IDX_W'(i);
      end
    end
  end

  assign x0 = pt(xs, int'(seg));
  assign x1 = pt(xs, int'(seg) + 1);
  assign y0 = pt(ys, int'(seg));
  assign y1 = pt(ys, int'(seg) + 1);

  // ---- shared multiplier: dy * off while in MUL, rate * step scale in STEP ----
  val_t                         mul_a;
  val_t                         mul_b;
  logic [sssl_pkg::NUM_W-1:0]   product;
  logic [sssl_pkg::RISE_W-1:0]  rise_new;

  always_comb begin
    if (state == ST_MUL) begin
      mul_a = dy_r;
      mul_b = off_r;
    end else begin
      mul_a = rate_r;
      mul_b = tbl ? sssl_pkg::TORQUE_STEP_MUL : sssl_pkg::GAIN_STEP_MUL;
    end
  end

  assign product  = {{sssl_pkg::VAL_W{1'b0}}, mul_a} * {{sssl_pkg::VAL_W{1'b0}}, mul_b};
  assign rise_new = product[sssl_pkg::STEP_SHIFT +: sssl_pkg::RISE_W];

  // Rounding term dx/2 rides on the numerator; quotient stays below 2^16
  assign div_req.start = (state == ST_MUL);
  assign div_req.num   = product + {{sssl_pkg::VAL_W{1'b0}}, 1'b0, dx_r[sssl_pkg::VAL_W-1:1]};
  assign div_req.den   = dx_r;

  sssl_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---- shared slew unit, one held value per cycle ----
  val_t                         h_sel;
  val_t                         t_sel;
  val_t                         fall_sel;
  logic [sssl_pkg::RISE_W-1:0]  rise_sel;
  logic [sssl_pkg::VAL_W:0]     lo_diff;
  logic [sssl_pkg::RISE_W:0]    hi_sum;
  val_t                         lo;
  val_t                         hi;
  val_t                         slew_v;
  logic                         is_gain_ch;

  assign is_gain_ch = (ch < sssl_pkg::CH_W'(2));
  assign h_sel      = held[ch];
  assign t_sel      = tgt[ch];
  assign fall_sel   = is_gain_ch ? gain_fall_step : torque_fall_step;
  assign rise_sel   = is_gain_ch ? rise_g : rise_t;
  assign lo_diff    = {1'b0, h_sel} - {1'b0, fall_sel};
  assign hi_sum     = {2'b00, h_sel} + {1'b0, rise_sel};
  assign lo         = lo_diff[sssl_pkg::VAL_W] ? '0 : lo_diff[sssl_pkg::VAL_W-1:0];
  assign hi         = (|hi_sum[sssl_pkg::RISE_W:sssl_pkg::VAL_W]) ? '1
                                                           : hi_sum[sssl_pkg::VAL_W-1:0];

  always_comb begin
    if (t_sel < lo) begin
      slew_v = lo;
    end else if (t_sel > hi) begin
      slew_v = hi;
    end else begin
      slew_v = t_sel;
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tbl       <= 1'b0;
      ch        <= '0;
      res_valid <= 1'b0;
      for (int j = 0; j < sssl_pkg::NUM_LIMITED; j++) begin
        held[j] <= '0;
      end
    end else begin
      // Load a finished tick, or drop the result once its transfer completes
      if (state == ST_DONE && (!res_valid || result.ready)) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            tbl   <= 1'b0;
            state <= ST_SEEK;
          end
        end
        ST_SEEK: begin
          if (below_first || !found) begin
            state <= ST_STEP;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (!tbl) begin
            tbl   <= 1'b1;
            state <= ST_SEEK;
          end else begin
            ch    <= '0;
            state <= ST_SLEW;
          end
        end
        ST_SLEW: begin
          held[ch] <= slew_v;
          if (ch == sssl_pkg::CH_W'(sssl_pkg::NUM_LIMITED - 1)) begin
            state <= ST_DONE;
          end else begin
            ch <= ch + 1'b1;
          end
        end
        ST_DONE: begin
          // Hold until the result register is free or being emptied
          if (!res_valid || result.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sample.valid) begin
      speed  <= sample.vehicle_speed;
      tgt[0] <= sample.eot_gain_target;
      tgt[1] <= sample.ramp_mult_target;
      tgt[2] <= sample.eot_limit_target;
      tgt[3] <= sample.stall_limit_target;
      tgt[4] <= sample.speed_limit_target;
      tgt[5] <= sample.thermal_limit_target;
    end

    if (state == ST_SEEK) begin
      if (below_first) begin
        rate_r <= pt(ys, 0);
      end else if (!found) begin
        rate_r <= pt(ys, sssl_pkg::TABLE_POINTS - 1);
      end
      y0_r  <= y0;
      neg_r <= (y1 < y0);
      dy_r  <= (y1 < y0) ? (y0 - y1) : (y1 - y0);
      off_r <= speed - x0;
      dx_r  <= x1 - x0;
    end

    // Apply the sign to the rounded magnitude
    if (state == ST_DIV && div_rsp.done) begin
      rate_r <= neg_r ? (y0_r - div_rsp.quot) : (y0_r + div_rsp.quot);
    end

    if (state == ST_STEP) begin
      if (tbl) begin
        rise_t <= rise_new;
      end else begin
        rise_g <= rise_new;
      end
    end

    if (state == ST_DONE && (!res_valid || result.ready)) begin
      for (int j = 0; j < sssl_pkg::NUM_LIMITED; j++) begin
        res[j] <= held[j];
      end
    end
  end

  assign sample.ready = (state == ST_IDLE);

  assign result.valid             = res_valid;
  assign result.eot_gain_out      = res[0];
  assign result.ramp_mult_out     = res[1];
  assign result.eot_limit_out     = res[2];
  assign result.stall_limit_out   = res[3];
  assign result.speed_limit_out   = res[4];
  assign result.thermal_limit_out = res[5];

  // ---- assertions ----
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIV)
    else $error("divider finished outside the wait state");

  a_div_to_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_rsp.done) |=> state == ST_STEP)
    else $error("quotient not followed by step scaling");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && (!result.valid || result.ready)) |=>
      (result.valid && state == ST_IDLE))
    else $error("finished tick not moved to the result register");

  a_slew_channel: assert property (@(posedge clk) disable iff (rst)
    state == ST_SLEW |-> ch < sssl_pkg::CH_W'(sssl_pkg::NUM_LIMITED))
    else $error("slew channel out of range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && sample.valid) |=> !sample.ready)
    else $error("sample accepted while a tick is in progress");

endmodule
